>>> hw/rtl/bright_blob_steering_defines.svh
// Assertion macros for the bright blob steering block.
`ifndef BRIGHT_BLOB_STEERING_DEFINES_SVH
`define BRIGHT_BLOB_STEERING_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define BBS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define BBS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define BBS_ASSERT(lbl, prop, msg)
`define BBS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/bbs_pkg.sv
// Shared types, constants and helpers for the bright blob steering block.
`timescale 1ns / 1ps

package bbs_pkg;

   localparam int MAX_ROW_BYTES = 4096;
   localparam int MAX_ROWS      = 4096;

   localparam int LEN_W   = 13;
   localparam int COL_W   = $clog2(MAX_ROW_BYTES);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int TOTAL_W = 25;
   localparam int CSUM_W  = 36;
   localparam int SPD_W   = 16;
   localparam int BORD_W  = 16;
   localparam int RATE_W  = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int SCALE_W  = TOTAL_W + LEN_W;
   localparam int SPLIT_W  = (SCALE_W + 1) / 2;
   localparam int PART_W   = BORD_W + SPLIT_W;
   localparam int PROD_W   = BORD_W + SCALE_W;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [CSUM_W-1:0]  CSUM_MAX  = {CSUM_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_BORDER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_BORDER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_SPEED    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_LINEAR  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_RATE    = 3'd7;

   // heading codes
   localparam logic [1:0] HEADING_NONE  = 2'd0;
   localparam logic [1:0] HEADING_LEFT  = 2'd1;
   localparam logic [1:0] HEADING_RIGHT = 2'd2;
   localparam logic [1:0] HEADING_AHEAD = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0]  row_bytes;
      logic [LEN_W-1:0]  row_count;
      logic [7:0]        white_level;
      logic [BORD_W-1:0] left_border;
      logic [BORD_W-1:0] right_border;
      logic [SPD_W-1:0]  forward_speed;
      logic [SPD_W-1:0]  turn_linear_speed;
      logic [RATE_W-1:0] turn_rate;
   } cfg_type;

   // one finished frame handed from front to back
   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [CSUM_W-1:0]  csum;
      logic [LEN_W-1:0]   len;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCALE,
      BK_PART,
      BK_DECIDE
   } back_state_type;

   // zero acts as one, oversize clamps to max
   function automatic logic [LEN_W-1:0] bound_size(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] max_v);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > max_v) begin
         r = max_v;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/bbs_front.sv
// Front part: pixel position counters, match counting and frame close.
`timescale 1ns / 1ps

module bbs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_pixel_byte,
   input  logic [7:0]                  white_level,
   input  logic [bbs_pkg::LEN_W-1:0]   len,
   input  logic [bbs_pkg::LEN_W-1:0]   rows,
   input  logic                        fifo_full,
   output logic                        push,
   output bbs_pkg::job_type            push_job
);

   logic [bbs_pkg::COL_W-1:0]   col_ff, col_in;
   logic [bbs_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [bbs_pkg::TOTAL_W-1:0] total_ff, total_in, total_nx;
   logic [bbs_pkg::CSUM_W-1:0]  csum_ff, csum_in, csum_nx;
   logic [bbs_pkg::CSUM_W:0]    csum_add;
   logic                        accept, match, col_last, row_last, frame_end;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   assign match     = (req_pixel_byte == white_level);

   assign col_last  = (bbs_pkg::LEN_W'({1'b0, col_ff}) + bbs_pkg::LEN_W'(1)) >= len;
   assign row_last  = (bbs_pkg::LEN_W'({1'b0, row_ff}) + bbs_pkg::LEN_W'(1)) >= rows;
   assign frame_end = col_last && row_last;

   always_comb begin
      csum_add = {1'b0, csum_ff} + (bbs_pkg::CSUM_W + 1)'(col_ff);
      total_nx = total_ff;
      csum_nx  = csum_ff;
      if (match) begin
         if (total_ff != bbs_pkg::TOTAL_MAX) begin
            total_nx = total_ff + bbs_pkg::TOTAL_W'(1);
         end
         csum_nx = csum_add[bbs_pkg::CSUM_W] ? bbs_pkg::CSUM_MAX
                                             : csum_add[bbs_pkg::CSUM_W-1:0];
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      total_in = total_ff;
      csum_in  = csum_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + bbs_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + bbs_pkg::COL_W'(1);
         end
         total_in = frame_end ? '0 : total_nx;
         csum_in  = frame_end ? '0 : csum_nx;
      end
   end

   assign push           = accept && frame_end;
   assign push_job.total = total_nx;
   assign push_job.csum  = csum_nx;
   assign push_job.len   = len;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         total_ff <= '0;
         csum_ff  <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         total_ff <= total_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

>>> hw/rtl/bbs_fifo.sv
// Two-entry queue of finished frames between front and back.
`timescale 1ns / 1ps

module bbs_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bbs_pkg::job_type push_job,
   input  logic             pop,
   output bbs_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);

   bbs_pkg::job_type                 mem_ff [bbs_pkg::FIFO_DEPTH];
   logic [bbs_pkg::FIFO_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [bbs_pkg::FIFO_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == bbs_pkg::FIFO_CNT_W'(bbs_pkg::FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = wr_ff + bbs_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
         rd_in = rd_ff + bbs_pkg::FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + bbs_pkg::FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - bbs_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/bbs_back.sv
// Back part: centroid versus border comparison and result register.
`timescale 1ns / 1ps

module bbs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  bbs_pkg::cfg_type             cfg,
   input  logic                         fifo_empty,
   input  bbs_pkg::job_type             fifo_job,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_linear_speed,
   output logic signed [15:0]           rsp_angular_speed,
   output logic [1:0]                   rsp_heading,
   output logic [24:0]                  rsp_match_count
);

   bbs_pkg::back_state_type          state_ff, state_in;
   bbs_pkg::job_type                 job_ff;
   logic [bbs_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [bbs_pkg::PART_W-1:0]       l_lo_ff, l_hi_ff, r_lo_ff, r_hi_ff;
   logic [bbs_pkg::PROD_W-1:0]       left_prod, right_prod, lhs;
   logic                             out_free, load_out, load_scale, load_part;
   logic                             valid_ff, valid_in;
   logic [15:0]                      lin_ff, lin_in;
   logic signed [15:0]               ang_ff, ang_in;
   logic [1:0]                       head_ff, head_in;
   logic [24:0]                      cnt_ff;

   assign out_free = !valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbs_pkg::BK_IDLE:   if (!fifo_empty) state_in = bbs_pkg::BK_SCALE;
         bbs_pkg::BK_SCALE:  state_in = bbs_pkg::BK_PART;
         bbs_pkg::BK_PART:   state_in = bbs_pkg::BK_DECIDE;
         bbs_pkg::BK_DECIDE: if (out_free) state_in = bbs_pkg::BK_IDLE;
         default:            state_in = bbs_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop        = 1'b0;
      load_scale = 1'b0;
      load_part  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         bbs_pkg::BK_IDLE:   pop        = !fifo_empty;
         bbs_pkg::BK_SCALE:  load_scale = 1'b1;
         bbs_pkg::BK_PART:   load_part  = 1'b1;
         bbs_pkg::BK_DECIDE: load_out   = out_free;
         default:            pop        = 1'b0;
      endcase
   end

   assign scale_in = bbs_pkg::SCALE_W'(job_ff.total) * bbs_pkg::SCALE_W'(job_ff.len);

   // border * scale rebuilt from two half-width partial products
   assign left_prod  = {l_hi_ff[bbs_pkg::PROD_W-bbs_pkg::SPLIT_W-1:0], bbs_pkg::SPLIT_W'(0)}
                     + bbs_pkg::PROD_W'(l_lo_ff);
   assign right_prod = {r_hi_ff[bbs_pkg::PROD_W-bbs_pkg::SPLIT_W-1:0], bbs_pkg::SPLIT_W'(0)}
                     + bbs_pkg::PROD_W'(r_lo_ff);
   assign lhs        = bbs_pkg::PROD_W'({job_ff.csum, 16'd0});

   always_comb begin
      if (job_ff.total == '0) begin
         head_in = bbs_pkg::HEADING_NONE;
         lin_in  = '0;
         ang_in  = '0;
      end else if (lhs < left_prod) begin
         head_in = bbs_pkg::HEADING_LEFT;
         lin_in  = cfg.turn_linear_speed;
         ang_in  = signed'({1'b0, cfg.turn_rate});
      end else if (lhs > right_prod) begin
         head_in = bbs_pkg::HEADING_RIGHT;
         lin_in  = cfg.turn_linear_speed;
         ang_in  = -signed'({1'b0, cfg.turn_rate});
      end else begin
         head_in = bbs_pkg::HEADING_AHEAD;
         lin_in  = cfg.forward_speed;
         ang_in  = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load_out) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbs_pkg::BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= fifo_job;
      end
      if (load_scale) begin
         scale_ff <= scale_in;
      end
      if (load_part) begin
         l_lo_ff <= bbs_pkg::PART_W'(cfg.left_border)
                  * bbs_pkg::PART_W'(scale_ff[bbs_pkg::SPLIT_W-1:0]);
         l_hi_ff <= bbs_pkg::PART_W'(cfg.left_border)
                  * bbs_pkg::PART_W'(scale_ff[bbs_pkg::SCALE_W-1:bbs_pkg::SPLIT_W]);
         r_lo_ff <= bbs_pkg::PART_W'(cfg.right_border)
                  * bbs_pkg::PART_W'(scale_ff[bbs_pkg::SPLIT_W-1:0]);
         r_hi_ff <= bbs_pkg::PART_W'(cfg.right_border)
                  * bbs_pkg::PART_W'(scale_ff[bbs_pkg::SCALE_W-1:bbs_pkg::SPLIT_W]);
      end
      if (load_out) begin
         lin_ff  <= lin_in;
         ang_ff  <= ang_in;
         head_ff <= head_in;
         cnt_ff  <= job_ff.total;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_linear_speed  = lin_ff;
   assign rsp_angular_speed = ang_ff;
   assign rsp_heading       = head_ff;
   assign rsp_match_count   = cnt_ff;

endmodule

>>> hw/rtl/bright_blob_steering.sv
// Top level of the bright blob steering block: registers, front, queue and back.
// Takes one pixel byte per cycle; the front stalls only while the frame queue is full.
// A result passes the queue, the scale multiply, the partial products and the compare
// in that order; the back takes a new frame only after the last result is loaded.
// Synchronous active-high reset restores the register defaults and clears
// the counters, sums, queue and result valid.
`timescale 1ns / 1ps
`include "bright_blob_steering_defines.svh"

module bright_blob_steering (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_pixel_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_linear_speed,
   output logic signed [15:0]                   rsp_angular_speed,
   output logic [1:0]                           rsp_heading,
   output logic [24:0]                          rsp_match_count,
   input  logic                                 csr_write,
   input  logic [bbs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bbs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   bbs_pkg::cfg_type              cfg_ff, cfg_in;
   bbs_pkg::job_type              push_job, pop_job;
   logic [bbs_pkg::LEN_W-1:0]     len, rows;
   logic                          push, pop, fifo_full, fifo_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bbs_pkg::CSR_ROW_BYTES:    cfg_in.row_bytes = csr_wdata[bbs_pkg::LEN_W-1:0];
            bbs_pkg::CSR_ROW_COUNT:    cfg_in.row_count = csr_wdata[bbs_pkg::LEN_W-1:0];
            bbs_pkg::CSR_WHITE_LEVEL:  cfg_in.white_level = csr_wdata[7:0];
            bbs_pkg::CSR_LEFT_BORDER:  cfg_in.left_border = csr_wdata;
            bbs_pkg::CSR_RIGHT_BORDER: cfg_in.right_border = csr_wdata;
            bbs_pkg::CSR_FWD_SPEED:    cfg_in.forward_speed = csr_wdata;
            bbs_pkg::CSR_TURN_LINEAR:  cfg_in.turn_linear_speed = csr_wdata;
            bbs_pkg::CSR_TURN_RATE:    cfg_in.turn_rate = csr_wdata[bbs_pkg::RATE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_bytes         <= 13'd2400;
         cfg_ff.row_count         <= 13'd800;
         cfg_ff.white_level       <= 8'd255;
         cfg_ff.left_border       <= 16'd21627;
         cfg_ff.right_border      <= 16'd43254;
         cfg_ff.forward_speed     <= 16'd128;
         cfg_ff.turn_linear_speed <= 16'd64;
         cfg_ff.turn_rate         <= 15'd128;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign len  = bbs_pkg::bound_size(cfg_ff.row_bytes,
                                     bbs_pkg::LEN_W'(bbs_pkg::MAX_ROW_BYTES));
   assign rows = bbs_pkg::bound_size(cfg_ff.row_count,
                                     bbs_pkg::LEN_W'(bbs_pkg::MAX_ROWS));

   bbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .white_level    (cfg_ff.white_level),
      .len            (len),
      .rows           (rows),
      .fifo_full      (fifo_full),
      .push           (push),
      .push_job       (push_job)
   );

   bbs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   bbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .fifo_empty        (fifo_empty),
      .fifo_job          (pop_job),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_angular_speed (rsp_angular_speed),
      .rsp_heading       (rsp_heading),
      .rsp_match_count   (rsp_match_count)
   );

   `BBS_ASSERT(a_no_overflow, !(push && fifo_full), "frame queue written while full")
   `BBS_ASSERT(a_no_underflow, !(pop && fifo_empty), "frame queue read while empty")
   `BBS_ASSERT(a_none_is_zero, (rsp_valid && rsp_heading == bbs_pkg::HEADING_NONE) |-> (rsp_linear_speed == '0 && rsp_angular_speed == '0 && rsp_match_count == '0), "stop result carries nonzero fields")
   `BBS_ASSERT(a_found_counts, (rsp_valid && rsp_heading != bbs_pkg::HEADING_NONE) |-> (rsp_match_count != '0), "heading given without matches")
   `BBS_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

>>> bench/bright_blob_steering_tb.sv
// Self-checking testbench for the bright blob steering block.
`timescale 1ns / 1ps

module bright_blob_steering_tb;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned RANDOM_ITEMS = 900;

   typedef struct packed {
      logic [bbs_pkg::SPD_W-1:0]   linear;
      logic [15:0]                 angular;
      logic [1:0]                  heading;
      logic [bbs_pkg::TOTAL_W-1:0] count;
   } steer_cmd_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [7:0]                     req_pixel_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [15:0]                    rsp_linear_speed;
   logic signed [15:0]             rsp_angular_speed;
   logic [1:0]                     rsp_heading;
   logic [24:0]                    rsp_match_count;
   logic                           csr_write;
   logic [bbs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bbs_pkg::CSR_DATA_W-1:0] csr_wdata;

   bright_blob_steering dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_byte    (req_pixel_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_angular_speed (rsp_angular_speed),
      .rsp_heading       (rsp_heading),
      .rsp_match_count   (rsp_match_count),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // tracker copy: configuration, counters and sums
   bbs_pkg::cfg_type            steer_cfg;
   logic [bbs_pkg::COL_W-1:0]   col_pos = '0;
   logic [bbs_pkg::ROW_W-1:0]   row_pos = '0;
   logic [bbs_pkg::TOTAL_W-1:0] white_total = '0;
   logic [bbs_pkg::CSUM_W-1:0]  column_sum = '0;

   logic [7:0]     pixel_queue[$];
   steer_cmd_type  steer_expect[$];
   int unsigned    pixels_taken = 0;
   int unsigned    error_count = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    hold_left = 0;
   bit             hold_off_req = 0;
   bit             req_taken = 0;
   logic           quiet_window;

   assign quiet_window = (pixels_taken >= 400) && (pixels_taken < 700);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [bbs_pkg::LEN_W-1:0] clamp_dim(
         input logic [bbs_pkg::LEN_W-1:0] v,
         input logic [bbs_pkg::LEN_W-1:0] top);
      return (v == '0) ? bbs_pkg::LEN_W'(1) : ((v > top) ? top : v);
   endfunction

   function automatic bbs_pkg::cfg_type make_cfg(input int unsigned rb, input int unsigned rc,
                                                 input int unsigned wl, input int unsigned lb,
                                                 input int unsigned rbd, input int unsigned fwd,
                                                 input int unsigned tl, input int unsigned rate);
      bbs_pkg::cfg_type c;
      c.row_bytes         = bbs_pkg::LEN_W'(rb);
      c.row_count         = bbs_pkg::LEN_W'(rc);
      c.white_level       = 8'(wl);
      c.left_border       = bbs_pkg::BORD_W'(lb);
      c.right_border      = bbs_pkg::BORD_W'(rbd);
      c.forward_speed     = bbs_pkg::SPD_W'(fwd);
      c.turn_linear_speed = bbs_pkg::SPD_W'(tl);
      c.turn_rate         = bbs_pkg::RATE_W'(rate);
      return c;
   endfunction

   // one accepted pixel: update counters, emit a command at frame end
   function automatic void track_pixel(input logic [7:0] px);
      logic [bbs_pkg::LEN_W-1:0] len;
      logic [bbs_pkg::LEN_W-1:0] rows;
      logic [63:0]               csum_next;
      logic [63:0]               lhs;
      logic [63:0]               scale;
      bit                        frame_done;
      steer_cmd_type             cmd;
      len  = clamp_dim(steer_cfg.row_bytes, bbs_pkg::LEN_W'(bbs_pkg::MAX_ROW_BYTES));
      rows = clamp_dim(steer_cfg.row_count, bbs_pkg::LEN_W'(bbs_pkg::MAX_ROWS));
      frame_done = 1'b0;
      if (px == steer_cfg.white_level) begin
         if (white_total != bbs_pkg::TOTAL_MAX) white_total++;
         csum_next = 64'(column_sum) + 64'(col_pos);
         column_sum = (csum_next > 64'(bbs_pkg::CSUM_MAX)) ? bbs_pkg::CSUM_MAX
                                                            : csum_next[bbs_pkg::CSUM_W-1:0];
      end
      if (64'(col_pos) + 64'd1 >= 64'(len)) begin
         col_pos = '0;
         if (64'(row_pos) + 64'd1 >= 64'(rows)) begin
            row_pos = '0;
            frame_done = 1'b1;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      if (frame_done) begin
         cmd.linear  = '0;
         cmd.angular = '0;
         cmd.heading = bbs_pkg::HEADING_NONE;
         cmd.count   = white_total;
         if (white_total != '0) begin
            lhs   = 64'(column_sum) << 16;
            scale = 64'(white_total) * 64'(len);
            if (lhs < 64'(steer_cfg.left_border) * scale) begin
               cmd.heading = bbs_pkg::HEADING_LEFT;
               cmd.linear  = steer_cfg.turn_linear_speed;
               cmd.angular = 16'(steer_cfg.turn_rate);
            end else if (lhs > 64'(steer_cfg.right_border) * scale) begin
               cmd.heading = bbs_pkg::HEADING_RIGHT;
               cmd.linear  = steer_cfg.turn_linear_speed;
               cmd.angular = 16'd0 - 16'(steer_cfg.turn_rate);
            end else begin
               cmd.heading = bbs_pkg::HEADING_AHEAD;
               cmd.linear  = steer_cfg.forward_speed;
            end
         end
         steer_expect.push_back(cmd);
         white_total = '0;
         column_sum  = '0;
      end
   endfunction

   // pixel items accepted by the block
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_taken = 1'b1;
         pixels_taken++;
         track_pixel(req_pixel_byte);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() != 0 && (quiet_window || $urandom_range(99) >= 30)) begin
            req_valid      <= 1'b1;
            req_pixel_byte <= pixel_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side stall, with one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_window && ($urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin : check_commands
      steer_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (steer_expect.size() == 0) begin
            $error("command with no frame pending: heading %0d, count %0d",
                   rsp_heading, rsp_match_count);
            error_count++;
         end else begin
            want = steer_expect.pop_front();
            if (rsp_linear_speed !== want.linear) begin
               $error("linear_speed: expected %0d, got %0d", want.linear, rsp_linear_speed);
               error_count++;
            end
            if (rsp_angular_speed !== $signed(want.angular)) begin
               $error("angular_speed: expected %0d, got %0d",
                      $signed(want.angular), rsp_angular_speed);
               error_count++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
               error_count++;
            end
            if (rsp_match_count !== want.count) begin
               $error("match_count: expected %0d, got %0d", want.count, rsp_match_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [bbs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bbs_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_setup(input bbs_pkg::cfg_type s);
      write_reg(bbs_pkg::CSR_ROW_BYTES,    bbs_pkg::CSR_DATA_W'(s.row_bytes));
      write_reg(bbs_pkg::CSR_ROW_COUNT,    bbs_pkg::CSR_DATA_W'(s.row_count));
      write_reg(bbs_pkg::CSR_WHITE_LEVEL,  bbs_pkg::CSR_DATA_W'(s.white_level));
      write_reg(bbs_pkg::CSR_LEFT_BORDER,  bbs_pkg::CSR_DATA_W'(s.left_border));
      write_reg(bbs_pkg::CSR_RIGHT_BORDER, bbs_pkg::CSR_DATA_W'(s.right_border));
      write_reg(bbs_pkg::CSR_FWD_SPEED,    bbs_pkg::CSR_DATA_W'(s.forward_speed));
      write_reg(bbs_pkg::CSR_TURN_LINEAR,  bbs_pkg::CSR_DATA_W'(s.turn_linear_speed));
      write_reg(bbs_pkg::CSR_TURN_RATE,    bbs_pkg::CSR_DATA_W'(s.turn_rate));
      @(negedge clock);
      csr_write <= 1'b0;
      steer_cfg = s;
   endtask

   // all items taken, all commands back, pipeline empty
   task automatic settle();
      while (pixel_queue.size() != 0 || req_valid) @(posedge clock);
      while (steer_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // queue one frame (or a leading piece of one) with a white blob in a column band
   function automatic int unsigned queue_frame(input int unsigned mix, input bit partial);
      int unsigned len, rows, n, pct, lo, hi, col;
      len  = 32'(clamp_dim(steer_cfg.row_bytes, bbs_pkg::LEN_W'(bbs_pkg::MAX_ROW_BYTES)));
      rows = 32'(clamp_dim(steer_cfg.row_count, bbs_pkg::LEN_W'(bbs_pkg::MAX_ROWS)));
      n    = len * rows;
      if (partial) n = $urandom_range(n - 1, 0);
      case (mix)
         0: pct = 0;
         1: pct = 100;
         2: pct = 60;
         default: pct = 25;
      endcase
      lo = $urandom_range(len - 1, 0);
      hi = $urandom_range(len - 1, lo);
      for (int unsigned i = 0; i < n; i++) begin
         col = i % len;
         if ((col >= lo && col <= hi && $urandom_range(99) < pct) ||
             (pct != 0 && $urandom_range(99) < pct / 8)) begin
            pixel_queue.push_back(steer_cfg.white_level);
         end else begin
            pixel_queue.push_back(8'($urandom_range(255)));
         end
      end
      return n;
   endfunction

   function automatic bbs_pkg::cfg_type random_cfg();
      int unsigned rb, rc, wl, lb, rbd, rate;
      case ($urandom_range(19))
         0, 1, 2:    rb = 0;
         3, 4, 5:    rb = $urandom_range(64, 9);
         default:    rb = $urandom_range(8, 1);
      endcase
      rc = ($urandom_range(4) == 0) ? 0 : $urandom_range(5, 1);
      case ($urandom_range(7))
         0:       wl = 0;
         1:       wl = 255;
         default: wl = $urandom_range(255);
      endcase
      if ($urandom_range(1) == 0) begin
         lb  = $urandom_range(32767);
         rbd = $urandom_range(65535, lb);
      end else begin
         lb  = $urandom_range(65535);
         rbd = $urandom_range(65535);
      end
      case ($urandom_range(7))
         0:       rate = 0;
         1:       rate = 32767;
         default: rate = $urandom_range(32767);
      endcase
      return make_cfg(rb, rc, wl, lb, rbd, $urandom_range(65535), $urandom_range(65535),
                      rate);
   endfunction

   initial begin : stimulus
      int unsigned random_items;
      steer_cfg      = make_cfg(2400, 800, 255, 21627, 43254, 128, 64, 128);
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel_byte = '0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two-byte rows, borders on the exact midpoint: tie goes ahead
      apply_setup(make_cfg(2, 1, 255, 32768, 32768, 65535, 0, 32767));
      pixel_queue.push_back(8'd0);   pixel_queue.push_back(8'd255);
      pixel_queue.push_back(8'd255); pixel_queue.push_back(8'd0);
      pixel_queue.push_back(8'd255); pixel_queue.push_back(8'd255);
      pixel_queue.push_back(8'd0);   pixel_queue.push_back(8'd0);
      settle();

      // zero sizes act as one; crossed borders, left test wins
      apply_setup(make_cfg(0, 0, 0, 65535, 0, 0, 65535, 1));
      pixel_queue.push_back(8'd0);
      pixel_queue.push_back(8'd255);
      settle();

      // zero borders: blob right of column 0 turns right
      apply_setup(make_cfg(3, 1, 0, 0, 0, 4660, 43981, 1));
      pixel_queue.push_back(8'd255); pixel_queue.push_back(8'd255);
      pixel_queue.push_back(8'd0);
      pixel_queue.push_back(8'd0);   pixel_queue.push_back(8'd255);
      pixel_queue.push_back(8'd255);
      settle();

      // frame shrunk while counters sit past the new last position
      apply_setup(make_cfg(4, 4, 128, 21627, 43254, 128, 64, 128));
      repeat (5) pixel_queue.push_back(8'd128);
      settle();
      apply_setup(make_cfg(1, 1, 128, 21627, 43254, 128, 64, 128));
      pixel_queue.push_back(8'd128);
      pixel_queue.push_back(8'd7);
      settle();

      // receiver holds off while one-byte frames keep coming
      apply_setup(make_cfg(1, 1, 2, 30000, 40000, 1000, 500, 300));
      hold_off_req = 1'b1;
      repeat (60) pixel_queue.push_back(8'($urandom_range(3)));
      settle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         apply_setup(random_cfg());
         repeat ($urandom_range(6, 1)) begin
            if (random_items < RANDOM_ITEMS) begin
               random_items += queue_frame($urandom_range(3), 1'b0);
            end
         end
         // leave a frame half done across the next setup
         if ($urandom_range(3) == 0) random_items += queue_frame($urandom_range(3), 1'b1);
         settle();
      end

      // oversized sizes clamp to the maximum; a shrink then closes the frame
      apply_setup(make_cfg(8191, 1, 200, 21627, 43254, 65535, 1, 32767));
      repeat (20) pixel_queue.push_back(8'($urandom_range(200, 199)));
      settle();
      apply_setup(make_cfg(1, 1, 200, 21627, 43254, 65535, 1, 32767));
      pixel_queue.push_back(8'd200);
      settle();
      apply_setup(make_cfg(1, 4097, 255, 0, 0, 12345, 54321, 777));
      repeat (20) pixel_queue.push_back(8'($urandom_range(255, 254)));
      settle();
      apply_setup(make_cfg(1, 1, 255, 0, 0, 12345, 54321, 777));
      pixel_queue.push_back(8'd255);
      settle();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
